/* hw/rtl/event_flag_wait_unit_defines.svh */
// assertion macros shared by the checker of the event flag wait unit
// depends on nothing; included by efwu_chk.sv
`ifndef EVENT_FLAG_WAIT_UNIT_DEFINES_SVH
`define EVENT_FLAG_WAIT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EFWU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efwu check failed");

// antecedent implies consequent in the next cycle
`define EFWU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("efwu check failed");

`endif

/* hw/rtl/efwu_pkg.sv */
// package of the event flag wait unit: defaults, codes, state type, helpers
// depends on nothing
package efwu_pkg;

   localparam int NUM_FLAGS_DEF    = 8;
   localparam int NUM_WAITERS_DEF  = 8;
   localparam int PATTERN_BITS_DEF = 16;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_WAIT  = 2'd2,
      OP_BAD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ID    = 3'd1,
      ST_BAD_PARAM = 3'd2,
      ST_BAD_CTX   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LOOK,
      S_TEST,
      S_LAST
   } state_type;

   // mode 0 needs all wanted bits, mode 1 any of them
   function automatic logic cond_holds(logic [31:0] have, logic [31:0] want,
                                       logic mode);
      if (!mode) return (have & want) == want;
      return (have & want) != 32'd0;
   endfunction

endpackage

/* hw/rtl/efwu_ram.sv */
// generic single-write, single-read ram with registered read data
// depends on nothing
module efwu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/event_flag_wait_unit.sv */
// Event flag unit for a hardware RTOS: NUM_FLAGS bit patterns and one shared
// table of waiting tasks kept in arrival order. Items are taken one at a time.
// Clear, wait and rejected items have their final result registered in the
// output register once it is free. A set visits the waiter entries in arrival
// order: each visit is a read of the waiter ram (registered read data) and a
// test, and the result side can stall it. A new item is taken once the final
// result is in the output register.
// Depends on efwu_pkg and efwu_ram.
module event_flag_wait_unit
   import efwu_pkg::*;
#(
   parameter int NUM_FLAGS    = NUM_FLAGS_DEF,
   parameter int NUM_WAITERS  = NUM_WAITERS_DEF,
   parameter int PATTERN_BITS = PATTERN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   // flag_id[3:0], pattern[19:4], wait_mode[21:20], task_id[29:22],
   // in_task_context[30], zero[31]
   input  logic [31:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], satisfied[3], pattern_out[19:4], woken_task[27:20], zero[31:28]
   output logic [31:0] rsp_tdata,
   // woken_valid[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   // clear_on_release register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int PW = PATTERN_BITS;
   localparam int FW = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
   localparam int SW = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
   localparam int OW = $clog2(NUM_WAITERS + 1);
   localparam int WW = 8 + PW + 1 + FW;

   // control and item registers
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [FW-1:0]     fidx_ff, fidx_in;
   logic              id_ok_ff, id_ok_in;
   logic [PW-1:0]     pat_ff, pat_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        task_ff, task_in;
   logic              ctx_ff, ctx_in;
   logic              clr_ff, clr_in;
   logic [7:0]        cor_ff;

   // flag patterns and waiter ordering
   logic [PW-1:0]     fpat_ff [NUM_FLAGS];
   logic [PW-1:0]     fpat_in [NUM_FLAGS];
   logic              wvalid_ff [NUM_WAITERS];
   logic              wvalid_in [NUM_WAITERS];
   logic [OW-1:0]     worder_ff [NUM_WAITERS];
   logic [OW-1:0]     worder_in [NUM_WAITERS];
   logic [OW-1:0]     count_ff, count_in;
   logic [OW-1:0]     rank_ff, rank_in;
   logic [SW-1:0]     slot_ff, slot_in;

   // output register
   logic              ov_ff, ov_in;
   status_type        ostat_ff, ostat_in;
   logic              osat_ff, osat_in;
   logic [15:0]       opat_ff, opat_in;
   logic              owoken_ff, owoken_in;
   logic [7:0]        otask_ff, otask_in;
   logic              olast_ff, olast_in;

   // waiter ram
   logic              ram_we, ram_re;
   logic [SW-1:0]     ram_wa, ram_ra;
   logic [WW-1:0]     ram_wd, ram_rd;
   logic [7:0]        rd_task;
   logic [PW-1:0]     rd_pat;
   logic              rd_mode;
   logic [FW-1:0]     rd_flag;

   // helpers
   logic              out_free;
   logic [PW-1:0]     cur_pat;
   logic [31:0]       cur32;
   logic [31:0]       req_pat32;
   logic [3:0]        req_id;
   logic [3:0]        req_fidx;
   logic [SW-1:0]     hit_slot;
   logic [SW-1:0]     free_slot;

   efwu_ram #(.WIDTH(WW), .DEPTH(NUM_WAITERS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign {rd_task, rd_pat, rd_mode, rd_flag} = ram_rd;

   assign out_free  = !ov_ff || rsp_tready;
   assign cur_pat   = fpat_ff[fidx_ff];
   assign cur32     = 32'(cur_pat);
   assign req_pat32 = {16'd0, req_tdata[19:4]};
   assign req_id    = req_tdata[3:0];
   assign req_fidx  = req_id - 4'd1;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'd0, otask_ff, opat_ff, osat_ff, ostat_ff};
   assign rsp_tuser  = owoken_ff;
   assign rsp_tlast  = olast_ff;

   // slot holding the waiter at the current rank, and first free slot
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      for (int i = NUM_WAITERS - 1; i >= 0; i--) begin
         if (wvalid_ff[i] && worder_ff[i] == rank_ff) hit_slot = SW'(i);
         if (!wvalid_ff[i]) free_slot = SW'(i);
      end
   end

   // state register and storage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cor_ff   <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < NUM_FLAGS; i++) fpat_ff[i] <= '0;
         for (int i = 0; i < NUM_WAITERS; i++) begin
            wvalid_ff[i] <= 1'b0;
            worder_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) cor_ff <= csr_data;
         count_ff <= count_in;
         ov_ff    <= ov_in;
         for (int i = 0; i < NUM_FLAGS; i++) fpat_ff[i] <= fpat_in[i];
         for (int i = 0; i < NUM_WAITERS; i++) begin
            wvalid_ff[i] <= wvalid_in[i];
            worder_ff[i] <= worder_in[i];
         end
      end
      op_ff     <= op_in;
      fidx_ff   <= fidx_in;
      id_ok_ff  <= id_ok_in;
      pat_ff    <= pat_in;
      mode_ff   <= mode_in;
      task_ff   <= task_in;
      ctx_ff    <= ctx_in;
      clr_ff    <= clr_in;
      rank_ff   <= rank_in;
      slot_ff   <= slot_in;
      ostat_ff  <= ostat_in;
      osat_ff   <= osat_in;
      opat_ff   <= opat_in;
      owoken_ff <= owoken_in;
      otask_ff  <= otask_in;
      olast_ff  <= olast_in;
   end

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      fidx_in   = fidx_ff;
      id_ok_in  = id_ok_ff;
      pat_in    = pat_ff;
      mode_in   = mode_ff;
      task_in   = task_ff;
      ctx_in    = ctx_ff;
      clr_in    = clr_ff;
      rank_in   = rank_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      fpat_in   = fpat_ff;
      wvalid_in = wvalid_ff;
      worder_in = worder_ff;
      ov_in     = ov_ff && !rsp_tready;
      ostat_in  = ostat_ff;
      osat_in   = osat_ff;
      opat_in   = opat_ff;
      owoken_in = owoken_ff;
      otask_in  = otask_ff;
      olast_in  = olast_ff;
      ram_we    = 1'b0;
      ram_wa    = free_slot;
      ram_wd    = {task_ff, pat_ff, mode_ff[0], fidx_ff};
      ram_re    = 1'b0;
      ram_ra    = hit_slot;

      // default final result: ok, nothing woken, only once the register is free
      if ((state_ff == S_EXEC || state_ff == S_LAST) && out_free) begin
         ostat_in  = ST_OK;
         osat_in   = 1'b0;
         opat_in   = '0;
         owoken_in = 1'b0;
         otask_in  = '0;
         olast_in  = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               id_ok_in = (req_id != 4'd0) && (req_id <= 4'(NUM_FLAGS));
               fidx_in  = FW'(req_fidx);
               pat_in   = req_pat32[PW-1:0];
               mode_in  = req_tdata[21:20];
               task_in  = req_tdata[29:22];
               ctx_in   = req_tdata[30];
               clr_in   = (req_fidx < 4'd8) && cor_ff[req_fidx[2:0]];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (op_ff == OP_SET && id_ok_ff) begin
               fpat_in[fidx_ff] = cur_pat | pat_ff;
               rank_in          = '0;
               state_in         = S_LOOK;
            end else if (out_free) begin
               ov_in    = 1'b1;
               state_in = S_IDLE;
               priority if (op_ff == OP_BAD) begin
                  ostat_in = ST_BAD_PARAM;
               end else if (!id_ok_ff) begin
                  ostat_in = ST_BAD_ID;
               end else if (op_ff == OP_CLEAR) begin
                  fpat_in[fidx_ff] = cur_pat & pat_ff;
               end else if (pat_ff == '0 || mode_ff[1]) begin
                  ostat_in = ST_BAD_PARAM;
               end else if (!ctx_ff) begin
                  ostat_in = ST_BAD_CTX;
               end else if (cond_holds(cur32, 32'(pat_ff), mode_ff[0])) begin
                  osat_in = 1'b1;
                  opat_in = cur32[15:0];
                  if (clr_ff) fpat_in[fidx_ff] = '0;
               end else if (count_ff == OW'(NUM_WAITERS)) begin
                  ostat_in = ST_FULL;
               end else begin
                  // enqueue at the first free slot, youngest rank
                  ram_we               = 1'b1;
                  wvalid_in[free_slot] = 1'b1;
                  worder_in[free_slot] = count_ff;
                  count_in             = count_ff + OW'(1);
               end
            end
         end

         // read the waiter at the current rank
         S_LOOK: begin
            if (rank_ff == count_ff) begin
               state_in = S_LAST;
            end else begin
               ram_re   = 1'b1;
               slot_in  = hit_slot;
               state_in = S_TEST;
            end
         end

         // test it against the current pattern and release it if met
         S_TEST: begin
            if (rd_flag != fidx_ff || !cond_holds(cur32, 32'(rd_pat), rd_mode)) begin
               rank_in  = rank_ff + OW'(1);
               state_in = S_LOOK;
            end else if (out_free) begin
               ov_in     = 1'b1;
               ostat_in  = ST_OK;
               osat_in   = 1'b0;
               opat_in   = cur32[15:0];
               owoken_in = 1'b1;
               otask_in  = rd_task;
               olast_in  = 1'b0;
               wvalid_in[slot_ff] = 1'b0;
               for (int i = 0; i < NUM_WAITERS; i++) begin
                  if (wvalid_ff[i] && worder_ff[i] > worder_ff[slot_ff])
                     worder_in[i] = worder_ff[i] - OW'(1);
               end
               count_in = count_ff - OW'(1);
               if (clr_ff) begin
                  fpat_in[fidx_ff] = '0;
                  state_in         = S_LAST;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_LAST: begin
            if (out_free) begin
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* hw/rtl/efwu_chk.sv */
// port-level checker of the event flag wait unit, bound to the top level
// depends on event_flag_wait_unit_defines.svh
`include "event_flag_wait_unit_defines.svh"

module efwu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [7:0]  csr_data
);

   // a stalled result holds
   `EFWU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // one item at a time: no new item right after one is taken
   `EFWU_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   // a release is never the final result and always ok
   `EFWU_ASSERT_NOW(a_woken_form, clock, reset, rsp_tvalid && rsp_tuser,
      !rsp_tlast && rsp_tdata[2:0] == 3'd0 && !rsp_tdata[3])

   // the final result names no task
   `EFWU_ASSERT_NOW(a_last_form, clock, reset, rsp_tvalid && rsp_tlast,
      !rsp_tuser && rsp_tdata[27:20] == 8'd0)

endmodule

bind event_flag_wait_unit efwu_chk u_efwu_chk (.*);
